### rtl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg: shared constants and helpers for the cartesian-to-spherical block
// Datapath widths, CORDIC arctangent table, gain correction and angle scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_COORD_WIDTH   = 16;

  // Coordinates are scaled so that value bits plus guard bits total 46
  localparam int COORD_TOTAL = 46;
  // Vector datapath width: headroom for CORDIC gain and 3D length
  localparam int DW = 50;
  // Angle accumulator width, Q30 with range past +/- (pi + sum of atan)
  localparam int AW = 35;
  // Number of entries in the arctangent table
  localparam int TAB_LEN = 24;

  // pi in Q30 and Q13
  localparam logic signed [AW-1:0] PI_Q30 = AW'(64'h00000000C90FDAA2);
  localparam int PI_Q13 = 25736;
  localparam int ANGLE_W = 16;
  localparam int THETA_W = 15;

  // 1/K in Q30, split multiply: upper slice above bit 16, lower 16 bits
  localparam int INV_K_W = 30;
  localparam logic [INV_K_W-1:0] INV_K_Q30 = 30'h26DD3B6A;
  localparam int GAIN_LO_W = 16;
  localparam int GAIN_HI_W = 32;

  // Flags that ride along with a point
  typedef struct packed {
    logic xy_zero;
    logic z_zero;
  } c2s_flags_t;

  localparam int FLAGS_W = $bits(c2s_flags_t);

  // atan(2^-i) in Q30, truncated
  function automatic logic [AW-1:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return AW'(v);
  endfunction

  // Q30 angle to Q13 with round-half-up, clamped to [lo, hi]
  function automatic logic signed [ANGLE_W-1:0] to_q13(
    input logic signed [AW-1:0] a,
    input logic signed [ANGLE_W-1:0] lo,
    input logic signed [ANGLE_W-1:0] hi
  );
    logic signed [AW-1:0]    s;
    logic signed [AW-18:0]   q;
    logic signed [ANGLE_W-1:0] r;
    s = a + AW'(65536);
    q = s[AW-1:17];
    if (q < (AW-17)'(lo)) begin
      r = lo;
    end else if (q > (AW-17)'(hi)) begin
      r = hi;
    end else begin
      r = q[ANGLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/cartesian_to_spherical_top.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_top: 3D point to radius, polar angle and azimuth
// Two CORDIC vectoring passes built as chains of rotation cells.
// ----------------------------------------------------------------------------
// Takes one point per clock while s_tready is high and returns one result per
// point, in order. Each vectoring pass is a chain of CORDIC_STAGES rotation
// cells behind one pre-rotation register, each gain correction is two stages,
// and one output register follows. A two-entry output buffer (output register
// plus skid register) keeps taking points while one result waits; s_tready
// drops only once both entries are full. Angles are radians in Q3.13; the
// origin gives theta = pi and phi = 0.
`default_nettype none

module cartesian_to_spherical_top
  import c2s_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  // fields from bit 0: x_coord, y_coord, z_coord, zero pad
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // fields from bit 0: radius, polar_angle, azimuth, zero pad
  output logic [((COORD_WIDTH+THETA_W+ANGLE_W+7)/8)*8-1:0] m_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready
);

  localparam int W      = COORD_WIDTH;
  localparam int GUARD  = COORD_TOTAL - COORD_WIDTH;
  localparam int OUT_W  = ((COORD_WIDTH+THETA_W+ANGLE_W+7)/8)*8;
  localparam int SIDE1_W = FLAGS_W + W;
  localparam int SIDEG1_W = AW + FLAGS_W + W;
  localparam int SIDE2_W = AW + FLAGS_W;
  localparam int SIDEG2_W = 2*AW + FLAGS_W;
  localparam logic [DW:0] RMAX = (DW+1)'((64'd1 << COORD_WIDTH) - 64'd1);
  localparam logic [DW:0] HALF = (DW+1)'(64'd1 << (GUARD-1));

  logic ce;

  // Input unpacking and scaling
  logic signed [W-1:0]  x_in;
  logic signed [W-1:0]  y_in;
  logic signed [W-1:0]  z_in;
  logic signed [DW-1:0] x_sc;
  logic signed [DW-1:0] y_sc;
  c2s_flags_t           flags_in;

  assign x_in = s_tdata[W-1:0];
  assign y_in = s_tdata[2*W-1:W];
  assign z_in = s_tdata[3*W-1:2*W];
  assign x_sc = DW'(x_in) <<< GUARD;
  assign y_sc = DW'(y_in) <<< GUARD;
  assign flags_in.xy_zero = (x_in == '0) && (y_in == '0);
  assign flags_in.z_zero  = (z_in == '0);

  // Pass 1: (x, y) -> rxy*K, phi
  logic                 p1_valid;
  logic signed [DW-1:0] p1_x;
  logic signed [AW-1:0] p1_a;
  logic [SIDE1_W-1:0]   p1_side;

  c2s_cordic_pass #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (SIDE1_W)
  ) u_pass1 (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid && s_tready),
    .in_x      (x_sc),
    .in_y      (y_sc),
    .in_side   ({flags_in, z_in}),
    .out_valid (p1_valid),
    .out_x     (p1_x),
    .out_a     (p1_a),
    .out_side  (p1_side)
  );

  // Gain correction of rxy
  logic                 g1_valid;
  logic signed [DW-1:0] g1_v;
  logic [SIDEG1_W-1:0]  g1_side;

  c2s_gain #(
    .SIDE_W (SIDEG1_W)
  ) u_gain1 (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (p1_valid),
    .in_v      (p1_x),
    .in_side   ({p1_a, p1_side}),
    .out_valid (g1_valid),
    .out_v     (g1_v),
    .out_side  (g1_side)
  );

  // Pass 2: (z, rxy) -> r*K, theta
  logic signed [W-1:0]  z_g1;
  logic signed [DW-1:0] z_sc;
  logic                 p2_valid;
  logic signed [DW-1:0] p2_x;
  logic signed [AW-1:0] p2_a;
  logic [SIDE2_W-1:0]   p2_side;

  assign z_g1 = g1_side[W-1:0];
  assign z_sc = DW'(z_g1) <<< GUARD;

  c2s_cordic_pass #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (SIDE2_W)
  ) u_pass2 (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (g1_valid),
    .in_x      (z_sc),
    .in_y      (g1_v),
    .in_side   (g1_side[SIDEG1_W-1:W]),
    .out_valid (p2_valid),
    .out_x     (p2_x),
    .out_a     (p2_a),
    .out_side  (p2_side)
  );

  // Gain correction of r
  logic                 g2_valid;
  logic signed [DW-1:0] g2_v;
  logic [SIDEG2_W-1:0]  g2_side;

  c2s_gain #(
    .SIDE_W (SIDEG2_W)
  ) u_gain2 (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (p2_valid),
    .in_v      (p2_x),
    .in_side   ({p2_a, p2_side}),
    .out_valid (g2_valid),
    .out_v     (g2_v),
    .out_side  (g2_side)
  );

  // Result formatting: round and saturate radius, scale angles, special cases
  logic signed [AW-1:0]      th_a;
  logic signed [AW-1:0]      phi_a;
  c2s_flags_t                flags_out;
  logic [DW:0]               r_sum;
  logic [DW:0]               r_shift;
  logic [W-1:0]              radius;
  logic signed [ANGLE_W-1:0] theta;
  logic signed [ANGLE_W-1:0] phi;
  logic [OUT_W-1:0]          result;

  assign th_a      = g2_side[SIDEG2_W-1:AW+FLAGS_W];
  assign phi_a     = g2_side[AW+FLAGS_W-1:FLAGS_W];
  assign flags_out = g2_side[FLAGS_W-1:0];

  always_comb begin
    r_sum   = {1'b0, g2_v} + HALF;
    r_shift = r_sum >> GUARD;
    radius  = (r_shift > RMAX) ? RMAX[W-1:0] : r_shift[W-1:0];
    theta   = to_q13(th_a, '0, ANGLE_W'(PI_Q13));
    phi     = to_q13(phi_a, -ANGLE_W'(PI_Q13), ANGLE_W'(PI_Q13));
    if (flags_out.xy_zero) begin
      phi = '0;
      if (flags_out.z_zero) begin
        theta = ANGLE_W'(PI_Q13);
      end
    end
    result = OUT_W'({phi, theta[THETA_W-1:0], radius});
  end

  // Output register with one skid entry
  logic             skid_valid;
  logic [OUT_W-1:0] skid;

  assign ce       = !skid_valid;
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (g2_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        m_tdata <= skid;
      end
    end else if (g2_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= result;
      end else begin
        skid <= result;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/c2s_cordic_cell.sv
// ----------------------------------------------------------------------------
// c2s_cordic_cell: one CORDIC vectoring micro-rotation
// Rotates (x, y) toward the x axis by atan(2^-SHIFT) and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_cordic_cell
  import c2s_pkg::*;
#(
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  ce,
  input  wire logic                  in_valid,
  input  wire logic signed [DW-1:0]  in_x,
  input  wire logic signed [DW-1:0]  in_y,
  input  wire logic signed [AW-1:0]  in_a,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_valid,
  output logic signed [DW-1:0]       out_x,
  output logic signed [DW-1:0]       out_y,
  output logic signed [AW-1:0]       out_a,
  output logic [SIDE_W-1:0]          out_side
);

  localparam logic signed [AW-1:0] ANGLE = atan_q30(SHIFT);

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] x_next;
  logic signed [DW-1:0] y_next;
  logic signed [AW-1:0] a_next;

  // Rotation direction follows the sign of y
  always_comb begin
    dx = in_y >>> SHIFT;
    dy = in_x >>> SHIFT;
    if (!in_y[DW-1]) begin
      x_next = in_x + dx;
      y_next = in_y - dy;
      a_next = in_a + ANGLE;
    end else begin
      x_next = in_x - dx;
      y_next = in_y + dy;
      a_next = in_a - ANGLE;
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ce) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_a    <= a_next;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

### rtl/c2s_cordic_pass.sv
// ----------------------------------------------------------------------------
// c2s_cordic_pass: one full CORDIC vectoring pass
// Left-half-plane pre-rotation register followed by a chain of rotation cells.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_cordic_pass
  import c2s_pkg::*;
#(
  parameter int STAGES = DEF_CORDIC_STAGES,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  ce,
  input  wire logic                  in_valid,
  input  wire logic signed [DW-1:0]  in_x,
  input  wire logic signed [DW-1:0]  in_y,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_valid,
  output logic signed [DW-1:0]       out_x,
  output logic signed [AW-1:0]       out_a,
  output logic [SIDE_W-1:0]          out_side
);

  logic                 vld [STAGES+1];
  logic signed [DW-1:0] xs  [STAGES+1];
  logic signed [DW-1:0] ys  [STAGES+1];
  logic signed [AW-1:0] as  [STAGES+1];
  logic [SIDE_W-1:0]    sd  [STAGES+1];

  logic signed [DW-1:0] pre_x;
  logic signed [DW-1:0] pre_y;
  logic signed [AW-1:0] pre_a;

  // Fold the left half plane onto the right, starting the angle at +/- pi
  always_comb begin
    if (in_x[DW-1]) begin
      pre_x = -in_x;
      pre_y = -in_y;
      pre_a = in_y[DW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      pre_x = in_x;
      pre_y = in_y;
      pre_a = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xs[0] <= pre_x;
      ys[0] <= pre_y;
      as[0] <= pre_a;
      sd[0] <= in_side;
    end
  end

  // Rotation cells, one per iteration
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    c2s_cordic_cell #(
      .SHIFT  (i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (vld[i]),
      .in_x      (xs[i]),
      .in_y      (ys[i]),
      .in_a      (as[i]),
      .in_side   (sd[i]),
      .out_valid (vld[i+1]),
      .out_x     (xs[i+1]),
      .out_y     (ys[i+1]),
      .out_a     (as[i+1]),
      .out_side  (sd[i+1])
    );
  end

  // The residual y is not needed downstream
  assign out_valid = vld[STAGES];
  assign out_x     = xs[STAGES];
  assign out_a     = as[STAGES];
  assign out_side  = sd[STAGES];

endmodule

`default_nettype wire

### rtl/c2s_gain.sv
// ----------------------------------------------------------------------------
// c2s_gain: CORDIC gain correction
// Multiplies a nonnegative value by 1/K in Q30 with truncation, two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_gain
  import c2s_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  ce,
  input  wire logic                  in_valid,
  input  wire logic signed [DW-1:0]  in_v,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_valid,
  output logic signed [DW-1:0]       out_v,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int HI_PW = GAIN_HI_W + INV_K_W;
  localparam int LO_PW = GAIN_LO_W + INV_K_W;

  logic                 vld1;
  logic [HI_PW-1:0]     hi_prod;
  logic [LO_PW-1:0]     lo_prod;
  logic [SIDE_W-1:0]    side1;
  logic [DW-1:0]        sum_next;

  // Valid bits for both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      vld1      <= in_valid;
      out_valid <= vld1;
    end
  end

  // Stage 1: partial products of upper and lower slices
  always_ff @(posedge clk) begin
    if (ce) begin
      hi_prod <= HI_PW'(in_v[GAIN_LO_W+GAIN_HI_W-1:GAIN_LO_W]) * HI_PW'(INV_K_Q30);
      lo_prod <= LO_PW'(in_v[GAIN_LO_W-1:0]) * LO_PW'(INV_K_Q30);
      side1   <= in_side;
    end
  end

  // Stage 2: align and add the truncated partials
  assign sum_next = DW'(hi_prod[HI_PW-1:INV_K_W-GAIN_LO_W])
                  + DW'(lo_prod[LO_PW-1:INV_K_W]);

  always_ff @(posedge clk) begin
    if (ce) begin
      out_v    <= $signed(sum_next);
      out_side <= side1;
    end
  end

endmodule

`default_nettype wire
